// File: rtl/core/dpcp_pkg.sv
// Shared types and constants of the delta patch command parser.
`timescale 1ns / 1ps

package dpcp_pkg;

   // Fixed field and header lengths of the patch format, in bytes.
   localparam int HDR_LEN  = 10;
   localparam int WORD_LEN = 4;
   localparam int CSUM_LEN = 16;

   // Bias added to the six-bit short length of copy and add opcodes.
   localparam int SHORT_BIAS = 5;

   localparam int FC_WIDTH = 5;

   // Opcode classes, taken from the top two bits of an opcode byte.
   localparam logic [1:0] OP_COPY = 2'b00;
   localparam logic [1:0] OP_CSUM = 2'b01;
   localparam logic [1:0] OP_ADD  = 2'b10;
   localparam logic [1:0] OP_SKIP = 2'b11;

   // Result command codes.
   localparam logic [1:0] CMD_COPY   = 2'd0;
   localparam logic [1:0] CMD_ADD    = 2'd1;
   localparam logic [1:0] CMD_TRUNC  = 2'd2;
   localparam logic [1:0] CMD_BADSEL = 2'd3;

   typedef enum logic [6:0] {
      PH_HEADER   = 7'b0000001,
      PH_OPCODE   = 7'b0000010,
      PH_COPY_OFF = 7'b0000100,
      PH_COPY_LEN = 7'b0001000,
      PH_ADD_LEN  = 7'b0010000,
      PH_ADD_DATA = 7'b0100000,
      PH_CSUM     = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic [7:0] patch_byte;
      logic       end_of_patch;
   } req_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] offset;
      logic [31:0] length;
   } rsp_type;

   // One decoded result leaving the parser.
   typedef struct packed {
      logic    valid;
      rsp_type rsp;
   } parse_out_type;

endpackage

// File: rtl/core/dpcp_parser.sv
// Byte-wise parse state machine of the delta patch command parser.
`timescale 1ns / 1ps

module dpcp_parser #(
   parameter int POS_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  dpcp_pkg::req_type       req,
   output dpcp_pkg::parse_out_type result
);
   import dpcp_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [POS_WIDTH-1:0]   pos_ff, pos_in, pos_inc;
   logic [FC_WIDTH-1:0]    fc_ff, fc_in, fc_inc;
   logic [31:0]            off_ff, off_in;
   logic [31:0]            len_ff, len_in;
   logic [5:0]             short_ff, short_in;
   logic [31:0]            skip_ff, skip_in, skip_dec;
   logic                   halted_ff, halted_in;

   logic                   fail;
   logic                   emit;
   logic [1:0]             cmd;
   logic [31:0]            res_off;
   logic [31:0]            res_len;
   logic [7:0]             b;
   logic                   last;

   assign b        = req.patch_byte;
   assign last     = req.end_of_patch;
   assign pos_inc  = pos_ff + POS_WIDTH'(1);
   assign fc_inc   = fc_ff + FC_WIDTH'(1);
   assign skip_dec = skip_ff - 32'(skip_ff != 32'd0);

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      fc_in     = fc_ff;
      off_in    = off_ff;
      len_in    = len_ff;
      short_in  = short_ff;
      skip_in   = skip_ff;
      halted_in = halted_ff;
      fail      = 1'b0;
      emit      = 1'b0;
      cmd       = CMD_COPY;
      res_off   = 32'd0;
      res_len   = 32'd0;

      if (accept && !halted_ff) begin
         case (phase_ff)
            PH_HEADER: begin
               fc_in = fc_inc;
               if (fc_ff == FC_WIDTH'(HDR_LEN - 1)) begin
                  fc_in    = '0;
                  phase_in = PH_OPCODE;
               end
            end
            PH_OPCODE: begin
               short_in = b[5:0];
               fc_in    = '0;
               case (b[7:6])
                  OP_COPY: begin
                     phase_in = PH_COPY_OFF;
                     fail     = last;
                     cmd      = CMD_TRUNC;
                  end
                  OP_ADD: begin
                     if (b[5:0] != 6'd0) begin
                        emit     = 1'b1;
                        cmd      = CMD_ADD;
                        res_off  = 32'(pos_inc);
                        res_len  = 32'(b[5:0]) + 32'(SHORT_BIAS);
                        skip_in  = res_len;
                        phase_in = PH_ADD_DATA;
                     end else begin
                        phase_in = PH_ADD_LEN;
                        fail     = last;
                        cmd      = CMD_TRUNC;
                     end
                  end
                  OP_CSUM: begin
                     phase_in = PH_CSUM;
                     if (b[5:0] > 6'd1) begin
                        fail = 1'b1;
                        cmd  = CMD_BADSEL;
                     end else begin
                        fail = last;
                        cmd  = CMD_TRUNC;
                     end
                  end
                  default: ;
               endcase
            end
            PH_COPY_OFF: begin
               off_in = {off_ff[23:0], b};
               fc_in  = fc_inc;
               if (fc_ff == FC_WIDTH'(WORD_LEN - 1)) begin
                  fc_in = '0;
                  if (short_ff != 6'd0) begin
                     emit     = 1'b1;
                     cmd      = CMD_COPY;
                     res_off  = off_in;
                     res_len  = 32'(short_ff) + 32'(SHORT_BIAS);
                     phase_in = PH_OPCODE;
                  end else begin
                     phase_in = PH_COPY_LEN;
                     fail     = last;
                     cmd      = CMD_TRUNC;
                  end
               end else begin
                  fail = last;
                  cmd  = CMD_TRUNC;
               end
            end
            PH_COPY_LEN, PH_ADD_LEN: begin
               len_in = {len_ff[23:0], b};
               fc_in  = fc_inc;
               if (fc_ff == FC_WIDTH'(WORD_LEN - 1)) begin
                  fc_in   = '0;
                  emit    = 1'b1;
                  res_len = len_in;
                  if (phase_ff == PH_COPY_LEN) begin
                     cmd      = CMD_COPY;
                     res_off  = off_ff;
                     phase_in = PH_OPCODE;
                  end else begin
                     cmd      = CMD_ADD;
                     res_off  = 32'(pos_inc);
                     skip_in  = len_in;
                     phase_in = (len_in != 32'd0) ? PH_ADD_DATA : PH_OPCODE;
                  end
               end else begin
                  fail = last;
                  cmd  = CMD_TRUNC;
               end
            end
            PH_ADD_DATA: begin
               skip_in = skip_dec;
               if (skip_dec == 32'd0) begin
                  phase_in = PH_OPCODE;
               end
            end
            PH_CSUM: begin
               fc_in = fc_inc;
               if (fc_ff == FC_WIDTH'(CSUM_LEN - 1)) begin
                  fc_in    = '0;
                  phase_in = PH_OPCODE;
               end else begin
                  fail = last;
                  cmd  = CMD_TRUNC;
               end
            end
            default: begin
               phase_in = PH_OPCODE;
            end
         endcase

         if (fail) begin
            // An error freezes the parser until the next reset.
            halted_in = 1'b1;
            emit      = 1'b1;
            res_off   = 32'd0;
            res_len   = 32'd0;
         end else begin
            pos_in = pos_inc;
            if (last) begin
               phase_in = PH_HEADER;
               pos_in   = '0;
               fc_in    = '0;
               off_in   = 32'd0;
               len_in   = 32'd0;
               short_in = 6'd0;
               skip_in  = 32'd0;
            end
         end
      end
   end

   assign result.valid       = emit;
   assign result.rsp.command = cmd;
   assign result.rsp.offset  = res_off;
   assign result.rsp.length  = res_len;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         pos_ff    <= '0;
         fc_ff     <= '0;
         skip_ff   <= 32'd0;
         halted_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         fc_ff     <= fc_in;
         skip_ff   <= skip_in;
         halted_ff <= halted_in;
      end
   end

   // Assembly registers are always fully written before they are read.
   always_ff @(posedge clock) begin
      off_ff   <= off_in;
      len_ff   <= len_in;
      short_ff <= short_in;
   end

   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("parser left the halted state without reset");

   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> !result.valid)
      else $error("halted parser produced a result");

   a_error_halts: assert property (@(posedge clock) disable iff (reset)
      result.valid && (result.rsp.command == CMD_TRUNC ||
                       result.rsp.command == CMD_BADSEL) |=> halted_ff)
      else $error("error result did not halt the parser");

   a_data_pending: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_ADD_DATA |-> skip_ff != 32'd0)
      else $error("add data phase with nothing left to skip");

endmodule

// File: rtl/core/delta_patch_command_parser.sv
// Top level of the delta patch command parser: parse core and result buffer.
`timescale 1ns / 1ps
// Results reach rsp_valid through the main entry register, via the skid entry if main is held.
// Throughput: one patch byte per cycle; req_stall rises only while both result entries are full.
// The parse state machine updates in the accept cycle; a two-entry buffer holds results.
// Reset (synchronous, active high) returns the parser to the header phase at byte position
// zero, clears the halt flag and empties the result buffer.

module delta_patch_command_parser #(
   parameter int POS_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dpcp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dpcp_pkg::rsp_type rsp_data
);
   import dpcp_pkg::*;

   // An item is taken whenever the overflow entry of the result buffer is
   // free. req_stall is a plain register output, so there is no combinational
   // path from rsp_stall back to req_stall.
   logic          accept;
   parse_out_type parsed;

   // Main entry drives the result port; the skid entry catches a result
   // that arrives while the main entry is held by a stalled consumer.
   logic    main_valid_ff, main_valid_in;
   rsp_type main_data_ff,  main_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff,  skid_data_in;
   logic    push;
   logic    pop;

   assign accept = req_valid && !skid_valid_ff;

   dpcp_parser #(
      .POS_WIDTH (POS_WIDTH)
   ) u_parser (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .result (parsed)
   );

   assign push = parsed.valid;
   assign pop  = main_valid_ff && !rsp_stall;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         // Input is stalled here, so no new result can arrive.
         if (pop) begin
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_valid_in = 1'b1;
            main_data_in  = parsed.rsp;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = parsed.rsp;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign req_stall = skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_data_ff;

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry holds a result ahead of an empty main entry");

   a_skid_held: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && rsp_stall |=> skid_valid_ff)
      else $error("skid entry dropped while the consumer stalled");

   a_overflow_to_skid: assert property (@(posedge clock) disable iff (reset)
      push && main_valid_ff && rsp_stall && !skid_valid_ff |=> skid_valid_ff)
      else $error("result arriving behind a stalled entry was not kept");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !push)
      else $error("result produced while the buffer was full");

endmodule

// File: bench/tb.sv
// Self-checking testbench of the delta patch command parser.
`timescale 1ns / 1ps

module tb;
   import dpcp_pkg::*;

   // Cycles without any accepted item, on either channel, before the run is declared hung.
   localparam int QUIET_LIMIT   = 2000;
   // Number of cycles the receiver holds off during the backpressure test.
   localparam int PRESSURE_HOLD = 80;
   // The random part keeps going until at least this many commands have been predicted.
   localparam int MIN_COMMANDS  = 40;

   // One byte of a patch under construction. can_end marks bytes after which the patch may
   // be closed without the parser reporting a truncated field.
   typedef struct {
      logic [7:0] value;
      bit         can_end;
   } patch_entry_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   // Commands the parser still owes, oldest first.
   rsp_type         expected_cmds[$];
   rsp_type         oldest_cmd;
   patch_entry_type patch_q[$];

   int unsigned items_sent     = 0;
   int unsigned cmds_predicted = 0;
   int unsigned mismatches     = 0;
   int unsigned quiet_cycles   = 0;
   int unsigned hold_request   = 0;
   bit          idle_on        = 1'b1;

   // Parser state as the testbench tracks it.
   phase_type   parse_phase;
   logic [31:0] patch_pos;
   int unsigned field_bytes;
   logic [31:0] copy_offset;
   logic [31:0] word_length;
   logic [5:0]  short_len;
   logic [31:0] data_left;
   bit          parser_halted;

   delta_patch_command_parser u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial forever #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Command prediction
   // ------------------------------------------------------------------

   // Back to the header phase at position zero, as after reset or a closed patch.
   function automatic void clear_patch_state();
      parse_phase = PH_HEADER;
      patch_pos   = '0;
      field_bytes = 0;
      copy_offset = '0;
      word_length = '0;
      short_len   = '0;
      data_left   = '0;
   endfunction

   function automatic void queue_cmd(logic [1:0] cmd, logic [31:0] off, logic [31:0] len);
      rsp_type r;
      r.command = cmd;
      r.offset  = off;
      r.length  = len;
      expected_cmds.push_back(r);
      cmds_predicted++;
   endfunction

   // An add with no data goes straight back to opcode parsing.
   function automatic void begin_add_data(logic [31:0] len);
      data_left   = len;
      parse_phase = (len != 0) ? PH_ADD_DATA : PH_OPCODE;
   endfunction

   // Advances the tracked parser by one accepted byte and queues the command it completes.
   function automatic void predict_parse(req_type item);
      logic [7:0]  b;
      logic [31:0] next_pos;
      logic [1:0]  err_cmd;
      bit          err_hit;
      b        = item.patch_byte;
      next_pos = patch_pos + 32'd1;
      err_hit  = 1'b0;
      err_cmd  = CMD_TRUNC;
      if (parser_halted) return;
      case (parse_phase)
         PH_HEADER: begin
            field_bytes++;
            if (field_bytes >= HDR_LEN) begin
               field_bytes = 0;
               parse_phase = PH_OPCODE;
            end
         end
         PH_OPCODE: begin
            short_len   = b[5:0];
            field_bytes = 0;
            case (b[7:6])
               OP_COPY: begin
                  copy_offset = '0;
                  parse_phase = PH_COPY_OFF;
                  err_hit     = item.end_of_patch;
               end
               OP_ADD: begin
                  if (b[5:0] != 6'd0) begin
                     // The data starts right after the opcode byte.
                     queue_cmd(CMD_ADD, next_pos, 32'(b[5:0]) + SHORT_BIAS);
                     begin_add_data(32'(b[5:0]) + SHORT_BIAS);
                  end else begin
                     word_length = '0;
                     parse_phase = PH_ADD_LEN;
                     err_hit     = item.end_of_patch;
                  end
               end
               OP_CSUM: begin
                  // A bad selector wins over truncation on the same byte.
                  if (b[5:0] > 6'd1) begin
                     err_hit = 1'b1;
                     err_cmd = CMD_BADSEL;
                  end else begin
                     parse_phase = PH_CSUM;
                     err_hit     = item.end_of_patch;
                  end
               end
               default: ;
            endcase
         end
         PH_COPY_OFF: begin
            copy_offset = {copy_offset[23:0], b};
            field_bytes++;
            if (field_bytes >= WORD_LEN) begin
               field_bytes = 0;
               if (short_len != 6'd0) begin
                  queue_cmd(CMD_COPY, copy_offset, 32'(short_len) + SHORT_BIAS);
                  parse_phase = PH_OPCODE;
               end else begin
                  word_length = '0;
                  parse_phase = PH_COPY_LEN;
                  err_hit     = item.end_of_patch;
               end
            end else begin
               err_hit = item.end_of_patch;
            end
         end
         PH_COPY_LEN, PH_ADD_LEN: begin
            word_length = {word_length[23:0], b};
            field_bytes++;
            if (field_bytes >= WORD_LEN) begin
               field_bytes = 0;
               if (parse_phase == PH_COPY_LEN) begin
                  queue_cmd(CMD_COPY, copy_offset, word_length);
                  parse_phase = PH_OPCODE;
               end else begin
                  queue_cmd(CMD_ADD, next_pos, word_length);
                  begin_add_data(word_length);
               end
            end else begin
               err_hit = item.end_of_patch;
            end
         end
         PH_ADD_DATA: begin
            if (data_left != 0) data_left--;
            if (data_left == 0) parse_phase = PH_OPCODE;
         end
         PH_CSUM: begin
            field_bytes++;
            if (field_bytes >= CSUM_LEN) begin
               field_bytes = 0;
               parse_phase = PH_OPCODE;
            end else begin
               err_hit = item.end_of_patch;
            end
         end
         default: parse_phase = PH_OPCODE;
      endcase
      if (err_hit) begin
         // Errors halt the parser until the next reset.
         parser_halted = 1'b1;
         queue_cmd(err_cmd, '0, '0);
      end else begin
         patch_pos = next_pos;
         if (item.end_of_patch) clear_patch_state();
      end
   endfunction

   // ------------------------------------------------------------------
   // Patch construction
   // ------------------------------------------------------------------

   function automatic void put_byte(logic [7:0] value, bit can_end);
      patch_entry_type e;
      e.value   = value;
      e.can_end = can_end;
      patch_q.push_back(e);
   endfunction

   // Big-endian word; only its last byte may close the patch, and only if the caller says so.
   function automatic void put_word(logic [31:0] word, bit can_end);
      for (int i = 3; i >= 0; i--) put_byte(word[8*i +: 8], can_end && i == 0);
   endfunction

   function automatic void put_header();
      repeat (HDR_LEN) put_byte(8'($urandom), 1'b1);
   endfunction

   function automatic void put_copy(logic [5:0] low, logic [31:0] off, logic [31:0] len);
      put_byte({OP_COPY, low}, 1'b0);
      put_word(off, low != 6'd0);
      if (low == 6'd0) put_word(len, 1'b1);
   endfunction

   // Add with its data; the short form is used where the length allows it, most of the time.
   function automatic void put_add(int unsigned len);
      if (len >= 6 && len <= 68 && $urandom_range(0, 3) != 0) begin
         put_byte({OP_ADD, 6'(len - SHORT_BIAS)}, 1'b1);
      end else begin
         put_byte({OP_ADD, 6'd0}, 1'b0);
         put_word(len, 1'b1);
      end
      repeat (len) put_byte(8'($urandom), 1'b1);
   endfunction

   function automatic void put_csum(logic sel);
      put_byte({OP_CSUM, 5'd0, sel}, 1'b0);
      for (int i = 0; i < CSUM_LEN; i++) put_byte(8'($urandom), i == CSUM_LEN - 1);
   endfunction

   // Appends one random command. Returns 1 when the command is an add far too long to send
   // in full, so that the patch has to be closed inside its data.
   function automatic bit put_random_command(bit allow_open);
      case ($urandom_range(0, 9))
         0, 1: put_copy(6'($urandom_range(1, 63)), $urandom, 32'd0);
         2: put_copy(6'd0, $urandom, $urandom);
         3, 4: put_add($urandom_range(0, 12));
         5: put_add($urandom_range(6, 68));
         6: begin
            if (allow_open) begin
               put_byte({OP_ADD, 6'd0}, 1'b0);
               put_word($urandom | 32'h100, 1'b1);
               repeat ($urandom_range(0, 6)) put_byte(8'($urandom), 1'b1);
               return 1'b1;
            end
            put_add($urandom_range(0, 8));
         end
         7: put_csum(1'($urandom_range(0, 1)));
         default: put_byte({OP_SKIP, 6'($urandom)}, 1'b1);
      endcase
      return 1'b0;
   endfunction

   // ------------------------------------------------------------------
   // Driving
   // ------------------------------------------------------------------

   // Offers one item and returns at the edge where it is accepted. Valid stays high
   // afterwards, so back-to-back items need no second assignment in the same step.
   task automatic send_item(input logic [7:0] value, input logic last);
      req_type item;
      item.patch_byte   = value;
      item.end_of_patch = last;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do begin
         @(posedge clock);
      end while (req_stall);
      predict_parse(item);
      items_sent++;
   endtask

   // Sends the patch under construction. With allow_cut it is sometimes closed early at a
   // point that is not an error, such as inside the header or inside add data. Without
   // close the final byte carries no end mark, so more bytes can follow.
   task automatic send_patch(input bit allow_cut, input bit close);
      int unsigned last_idx;
      int unsigned end_points[$];
      last_idx = patch_q.size() - 1;
      if (allow_cut && $urandom_range(0, 4) == 0) begin
         foreach (patch_q[i]) if (patch_q[i].can_end) end_points.push_back(i);
         last_idx = end_points[$urandom_range(0, end_points.size() - 1)];
      end
      for (int unsigned i = 0; i <= last_idx; i++)
         send_item(patch_q[i].value, close && i == last_idx);
      patch_q.delete();
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Extremes in one short patch: the largest short copy at offset all ones, a zero-length
   // add, an ignored opcode of all ones, and a patch that ends inside add data.
   task automatic test_directed_commands();
      put_header();
      put_copy(6'h3f, 32'hffff_ffff, 32'd0);
      put_byte({OP_ADD, 6'd0}, 1'b0);
      put_word(32'd0, 1'b1);
      put_byte(8'hff, 1'b1);
      put_byte({OP_ADD, 6'd1}, 1'b1);
      put_byte(8'h00, 1'b1);
      put_byte(8'h00, 1'b1);
      send_patch(1'b0, 1'b1);
   endtask

   // Well-formed patches with random content, some cut short at harmless points, and now
   // and then a patch that is only a header.
   task automatic test_random_patches(input int unsigned count, input int unsigned min_cmds);
      int unsigned start;
      start = items_sent;
      while (items_sent - start < count || cmds_predicted < min_cmds) begin
         put_header();
         if ($urandom_range(0, 9) != 0) begin
            repeat ($urandom_range(1, 6)) begin
               if (put_random_command(1'b1)) break;
            end
         end
         send_patch(1'b1, 1'b1);
      end
   endtask

   // The receiver holds off long enough for the result buffer to fill, so the parser has
   // to stall its input while the sender keeps offering short copies.
   task automatic test_result_backpressure();
      put_header();
      repeat (12) put_copy(6'($urandom_range(1, 63)), $urandom, 32'd0);
      hold_request = PRESSURE_HOLD;
      send_patch(1'b0, 1'b1);
   endtask

   // A valid prefix followed by either a bad checksum selector or a field cut off by the
   // end mark. The parser must report the error once and then ignore everything after it.
   task automatic test_halt_on_error();
      logic [7:0]  opcode;
      int unsigned needed;
      int unsigned sent_bytes;
      put_header();
      repeat ($urandom_range(1, 3)) void'(put_random_command(1'b0));
      send_patch(1'b0, 1'b0);
      case ($urandom_range(0, 3))
         0: begin
            opcode = {OP_COPY, 6'($urandom)};
            needed = (opcode[5:0] != 6'd0) ? WORD_LEN : 2 * WORD_LEN;
         end
         1: begin
            opcode = {OP_ADD, 6'd0};
            needed = WORD_LEN;
         end
         2: begin
            opcode = {OP_CSUM, 5'd0, 1'($urandom_range(0, 1))};
            needed = CSUM_LEN;
         end
         default: begin
            opcode = {OP_CSUM, 6'($urandom_range(2, 63))};
            needed = 0;
         end
      endcase
      if (needed == 0) begin
         send_item(opcode, 1'($urandom_range(0, 1)));
      end else begin
         // End the patch somewhere before the field is complete, possibly on the opcode.
         sent_bytes = $urandom_range(0, needed - 1);
         send_item(opcode, sent_bytes == 0);
         for (int unsigned i = 1; i <= sent_bytes; i++)
            send_item(8'($urandom), i == sent_bytes);
      end
      repeat (20) send_item(8'($urandom), 1'($urandom_range(0, 1)));
   endtask

   // ------------------------------------------------------------------
   // Result receiver: random stalls, plus one long hold-off on request
   // ------------------------------------------------------------------

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_request) @(posedge clock);
            hold_request = 0;
            rsp_stall <= 1'b0;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 3)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // Past time zero these signals change only by nonblocking assignments, so the values
   // read here are the ones that were present just before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_cmds.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %p", $time, rsp_data);
            mismatches++;
         end else begin
            oldest_cmd = expected_cmds.pop_front();
            check_field("command", 32'(oldest_cmd.command), 32'(rsp_data.command));
            check_field("offset", oldest_cmd.offset, rsp_data.offset);
            check_field("length", oldest_cmd.length, rsp_data.length);
         end
      end
   end

   // Watchdog: the run is hung when nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, expected_cmds.size());
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Sequence of tests
   // ------------------------------------------------------------------

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      parser_halted = 1'b0;
      clear_patch_state();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_directed_commands();
      test_random_patches(160, 0);
      test_result_backpressure();
      test_random_patches(100, 0);
      // The last stretch runs at full rate on both sides.
      idle_on = 1'b0;
      test_random_patches(60, MIN_COMMANDS);
      // An error halts the parser for good, so it comes last.
      test_halt_on_error();

      req_valid <= 1'b0;
      while (expected_cmds.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// File: delta_patch_command_parser.f
rtl/core/dpcp_pkg.sv
rtl/core/dpcp_parser.sv
rtl/core/delta_patch_command_parser.sv
bench/tb.sv
